### rtl/adm_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the arcade drive mixer.
// No dependencies; the design files that use it refer to it by scoped names, the bench imports it.
package adm_pkg;

  // Register indexes of the configuration port.
  localparam int CFG_INDEX_BITS = 3;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_LEFT_NEUTRAL  = 3'd0,
    REG_LEFT_MIN      = 3'd1,
    REG_LEFT_MAX      = 3'd2,
    REG_RIGHT_NEUTRAL = 3'd3,
    REG_RIGHT_MIN     = 3'd4,
    REG_RIGHT_MAX     = 3'd5
  } adm_reg_t;

  // Register values after reset, masked to the output width on load.
  localparam int RST_NEUTRAL = 1500;
  localparam int RST_MIN     = 1000;
  localparam int RST_MAX     = 2000;

  // Pipeline depth: a..c in the mixer, d..g in each side mapper.
  localparam int NUM_STAGES = 7;

  // Load enables of the pipeline stages, one per stage.
  typedef struct packed {
    logic a;
    logic b;
    logic c;
    logic d;
    logic e;
    logic f;
    logic g;
  } adm_stage_en_t;

endpackage

### rtl/adm_axis_if.sv
`timescale 1ns / 1ps
// Input channel of the mixer: one joystick axis pair per item.
// Valid/ready handshake; no dependencies.
interface adm_axis_if #(
  parameter int AXIS_BITS = 16
);
  logic                        valid;
  logic                        ready;
  logic signed [AXIS_BITS-1:0] x_axis;
  logic signed [AXIS_BITS-1:0] y_axis;

  modport source (output valid, output x_axis, output y_axis, input ready);
  modport sink   (input valid, input x_axis, input y_axis, output ready);
endinterface

### rtl/adm_drive_if.sv
`timescale 1ns / 1ps
// Output channel of the mixer: one left/right drive pair per item.
// Valid/ready handshake; no dependencies.
interface adm_drive_if #(
  parameter int OUT_BITS = 16
);
  logic                valid;
  logic                ready;
  logic [OUT_BITS-1:0] left_value;
  logic [OUT_BITS-1:0] right_value;

  modport source (output valid, output left_value, output right_value, input ready);
  modport sink   (input valid, input left_value, input right_value, output ready);
endinterface

### rtl/arcade_drive_mixer_top.sv
`timescale 1ns / 1ps
// Arcade drive mixer: top level with configuration registers and pipeline control.
// Depends on adm_pkg, adm_axis_if, adm_drive_if, adm_mix and adm_side.
//
// Usage:
//   in  (adm_axis_if sink): one x_axis/y_axis pair per item, signed Q1.(AXIS_BITS-1).
//       Throttle is the negated x_axis, steer is y_axis.
//   out (adm_drive_if source): one left_value/right_value pair per item, in order.
//   cfg: cfg_wr_en, cfg_index, cfg_data write neutral/min/max of each side;
//       indexes beyond the list are ignored. Write only while no item is in flight.
//   Pipeline: seven register stages from in to out (prep, mix multiply, side
//       sum/clamp, end select, partial products, product join, round/clamp).
//       The last stage is the output register.
//   Throughput: one item per cycle while the receiver takes items; each stage holds one item.
//   Reset (rst, synchronous): empties the pipeline and loads the registers with
//       neutral 1500, min 1000, max 2000 on both sides.
//   Receiver stall: out holds its item while ready is low; stages behind it
//       keep filling empty slots, so in.ready drops only when all seven stages
//       hold items.
module arcade_drive_mixer_top #(
  parameter int AXIS_BITS = 16,
  parameter int OUT_BITS  = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  adm_axis_if.sink                          in,
  adm_drive_if.source                       out,
  input  logic                              cfg_wr_en,
  input  logic [adm_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [OUT_BITS-1:0]               cfg_data
);
  localparam int NS = adm_pkg::NUM_STAGES;

  // Configuration registers
  logic [OUT_BITS-1:0] left_neutral, left_min, left_max;
  logic [OUT_BITS-1:0] right_neutral, right_min, right_max;

  always_ff @(posedge clk) begin
    if (rst) begin
      left_neutral  <= OUT_BITS'(adm_pkg::RST_NEUTRAL);
      left_min      <= OUT_BITS'(adm_pkg::RST_MIN);
      left_max      <= OUT_BITS'(adm_pkg::RST_MAX);
      right_neutral <= OUT_BITS'(adm_pkg::RST_NEUTRAL);
      right_min     <= OUT_BITS'(adm_pkg::RST_MIN);
      right_max     <= OUT_BITS'(adm_pkg::RST_MAX);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        adm_pkg::REG_LEFT_NEUTRAL:  left_neutral  <= cfg_data;
        adm_pkg::REG_LEFT_MIN:      left_min      <= cfg_data;
        adm_pkg::REG_LEFT_MAX:      left_max      <= cfg_data;
        adm_pkg::REG_RIGHT_NEUTRAL: right_neutral <= cfg_data;
        adm_pkg::REG_RIGHT_MIN:     right_min     <= cfg_data;
        adm_pkg::REG_RIGHT_MAX:     right_max     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pipeline control: a stage loads when it is empty or its item moves on
  logic [NS-1:0]          vld;
  logic [NS-1:0]          rdy;
  adm_pkg::adm_stage_en_t en;

  always_comb begin
    rdy[NS-1] = !vld[NS-1] || out.ready;
    for (int i = NS - 2; i >= 0; i--) begin
      rdy[i] = !vld[i] || rdy[i+1];
    end
    en = adm_pkg::adm_stage_en_t'({rdy[0], rdy[1], rdy[2], rdy[3], rdy[4], rdy[5], rdy[6]});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= in.valid;
      end
      for (int i = 1; i < NS; i++) begin
        if (rdy[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  assign in.ready  = rdy[0];
  assign out.valid = vld[NS-1];

  // Datapath
  logic                   left_neg, right_neg;
  logic [2*AXIS_BITS-1:0] left_mag, right_mag;
  logic [OUT_BITS-1:0]    left_out, right_out;

  adm_mix #(
    .AXIS_BITS (AXIS_BITS)
  ) u_mix (
    .clk       (clk),
    .en        (en),
    .x_axis    (in.x_axis),
    .y_axis    (in.y_axis),
    .left_neg  (left_neg),
    .left_mag  (left_mag),
    .right_neg (right_neg),
    .right_mag (right_mag)
  );

  adm_side #(
    .AXIS_BITS (AXIS_BITS),
    .OUT_BITS  (OUT_BITS)
  ) u_side_left (
    .clk       (clk),
    .en        (en),
    .neg       (left_neg),
    .mag       (left_mag),
    .neutral   (left_neutral),
    .min_value (left_min),
    .max_value (left_max),
    .value     (left_out)
  );

  adm_side #(
    .AXIS_BITS (AXIS_BITS),
    .OUT_BITS  (OUT_BITS)
  ) u_side_right (
    .clk       (clk),
    .en        (en),
    .neg       (right_neg),
    .mag       (right_mag),
    .neutral   (right_neutral),
    .min_value (right_min),
    .max_value (right_max),
    .value     (right_out)
  );

  assign out.left_value  = left_out;
  assign out.right_value = right_out;

endmodule

### rtl/adm_mix.sv
`timescale 1ns / 1ps
// Stages a..c: throttle/steer prep, arcade mix products, side sums with clamp.
// Depends on adm_pkg for the stage enable struct.
module adm_mix #(
  parameter int AXIS_BITS = 16
) (
  input  logic                        clk,
  input  adm_pkg::adm_stage_en_t      en,
  input  logic signed [AXIS_BITS-1:0] x_axis,
  input  logic signed [AXIS_BITS-1:0] y_axis,
  output logic                        left_neg,
  output logic [2*AXIS_BITS-1:0]      left_mag,
  output logic                        right_neg,
  output logic [2*AXIS_BITS-1:0]      right_mag
);
  localparam int A  = AXIS_BITS;
  localparam int PW = 2*A + 2;   // v and w
  localparam int SW = 2*A + 3;   // v + w, v - w
  localparam logic [A:0]    TWO_F = {1'b1, {A{1'b0}}};
  localparam logic [SW-1:0] LIM   = SW'(1) << (2*A - 1);

  // Stage a
  logic signed [A:0] x_ext, t_next, t_abs, s_abs;
  logic signed [A:0] t, s;
  logic [A:0]        ks, kt;

  always_comb begin
    x_ext  = {x_axis[A-1], x_axis};
    t_next = -x_ext;
    t_abs  = t_next[A] ? -t_next : t_next;
    s_abs  = y_axis[A-1] ? -$signed({y_axis[A-1], y_axis}) : $signed({y_axis[A-1], y_axis});
  end

  always_ff @(posedge clk) begin
    if (en.a) begin
      t  <= t_next;
      s  <= {y_axis[A-1], y_axis};
      ks <= TWO_F - {1'b0, s_abs[A-1:0]};
      kt <= TWO_F - {1'b0, t_abs[A-1:0]};
    end
  end

  // Stage b: v = t*(2F - |s|), w = s*(2F - |t|)
  logic signed [PW:0]   v_prod, w_prod;
  logic signed [PW-1:0] v, w;

  always_comb begin
    v_prod = t * $signed({1'b0, ks});
    w_prod = s * $signed({1'b0, kt});
  end

  always_ff @(posedge clk) begin
    if (en.b) begin
      v <= v_prod[PW-1:0];
      w <= w_prod[PW-1:0];
    end
  end

  // Stage c: side sums, split into sign and clamped magnitude
  logic signed [SW-1:0] l_sum, r_sum, l_abs, r_abs;

  always_comb begin
    l_sum = $signed({v[PW-1], v}) + $signed({w[PW-1], w});
    r_sum = $signed({v[PW-1], v}) - $signed({w[PW-1], w});
    l_abs = l_sum[SW-1] ? -l_sum : l_sum;
    r_abs = r_sum[SW-1] ? -r_sum : r_sum;
  end

  always_ff @(posedge clk) begin
    if (en.c) begin
      left_neg  <= l_sum[SW-1];
      right_neg <= r_sum[SW-1];
      left_mag  <= ($unsigned(l_abs) > LIM) ? LIM[2*A-1:0] : l_abs[2*A-1:0];
      right_mag <= ($unsigned(r_abs) > LIM) ? LIM[2*A-1:0] : r_abs[2*A-1:0];
    end
  end

endmodule

### rtl/adm_side.sv
`timescale 1ns / 1ps
// Stages d..g of one side: map drive onto neutral..end, floor, clamp to min/max.
// Depends on adm_pkg for the stage enable struct.
module adm_side #(
  parameter int AXIS_BITS = 16,
  parameter int OUT_BITS  = 16
) (
  input  logic                   clk,
  input  adm_pkg::adm_stage_en_t en,
  input  logic                   neg,
  input  logic [2*AXIS_BITS-1:0] mag,
  input  logic [OUT_BITS-1:0]    neutral,
  input  logic [OUT_BITS-1:0]    min_value,
  input  logic [OUT_BITS-1:0]    max_value,
  output logic [OUT_BITS-1:0]    value
);
  localparam int A  = AXIS_BITS;
  localparam int OW = OUT_BITS;
  localparam int K  = 2*A - 1;       // drive scale: full scale is 2^K
  localparam int PP = OW + A;        // partial product width
  localparam int FW = OW + 2*A;      // full product width

  // Stage d: distance to the end point and the clamp bounds
  logic signed [OW:0] diff, diff_abs;
  logic [OW-1:0]      end_sel;
  logic               d_neg;
  logic [OW-1:0]      d_abs, d_n, d_lo, d_hi;
  logic [2*A-1:0]     d_mag;

  always_comb begin
    end_sel  = neg ? min_value : max_value;
    diff     = $signed({1'b0, end_sel}) - $signed({1'b0, neutral});
    diff_abs = diff[OW] ? -diff : diff;
  end

  always_ff @(posedge clk) begin
    if (en.d) begin
      d_neg <= diff[OW];
      d_abs <= diff_abs[OW-1:0];
      d_mag <= mag;
      d_n   <= neutral;
      d_lo  <= (min_value < max_value) ? min_value : max_value;
      d_hi  <= (min_value < max_value) ? max_value : min_value;
    end
  end

  // Stage e: two partial products over the low and high halves of the drive
  logic [PP-1:0] e_plo, e_phi;
  logic          e_neg;
  logic [OW-1:0] e_n, e_lo, e_hi;

  always_ff @(posedge clk) begin
    if (en.e) begin
      e_plo <= d_abs * d_mag[A-1:0];
      e_phi <= d_abs * d_mag[2*A-1:A];
      e_neg <= d_neg;
      e_n   <= d_n;
      e_lo  <= d_lo;
      e_hi  <= d_hi;
    end
  end

  // Stage f: join the halves, take the quotient and the lost remainder
  logic [FW-1:0] prod;
  logic [OW-1:0] f_q, f_n, f_lo, f_hi;
  logic          f_neg, f_inexact;

  always_comb begin
    prod = {e_phi, {A{1'b0}}} + {{A{1'b0}}, e_plo};
  end

  always_ff @(posedge clk) begin
    if (en.f) begin
      f_q       <= prod[K+OW-1:K];
      f_inexact <= |prod[K-1:0];
      f_neg     <= e_neg;
      f_n       <= e_n;
      f_lo      <= e_lo;
      f_hi      <= e_hi;
    end
  end

  // Stage g: round toward minus infinity, then clamp
  logic signed [OW+1:0] n_ext, q_ext, inx_ext, res, lo_ext, hi_ext;
  logic [OW-1:0]        value_next;

  always_comb begin
    n_ext   = $signed({2'b00, f_n});
    q_ext   = $signed({2'b00, f_q});
    inx_ext = $signed({{(OW+1){1'b0}}, f_inexact});
    lo_ext  = $signed({2'b00, f_lo});
    hi_ext  = $signed({2'b00, f_hi});
    res     = f_neg ? (n_ext - q_ext - inx_ext) : (n_ext + q_ext);
    if (res > hi_ext) begin
      value_next = f_hi;
    end else if (res < lo_ext) begin
      value_next = f_lo;
    end else begin
      value_next = res[OW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en.g) begin
      value <= value_next;
    end
  end

endmodule

### rtl/adm_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the arcade drive mixer, bound to the top level.
// Depends on arcade_drive_mixer_top and its interfaces.
module adm_checker #(
  parameter int OUT_BITS = 16
) (
  input logic                clk,
  input logic                rst,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [OUT_BITS-1:0] left_value,
  input logic [OUT_BITS-1:0] right_value
);

  // A stalled result keeps its item
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(left_value) && $stable(right_value))
    else $error("output item changed or dropped while stalled");

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

  // A draining receiver never throttles the input
  a_full_rate: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("input stalled while output is taken");

endmodule

bind arcade_drive_mixer_top adm_checker #(
  .OUT_BITS (OUT_BITS)
) u_adm_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (in.ready),
  .out_valid   (out.valid),
  .out_ready   (out.ready),
  .left_value  (out.left_value),
  .right_value (out.right_value)
);

### test/arcade_drive_mixer_top_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for arcade_drive_mixer_top: axis pairs go in, and each drive pair
// out is compared with a bit-exact mixer/scaler model kept here. Uses adm_pkg and both
// channel interfaces.
module arcade_drive_mixer_top_tb;
  import adm_pkg::*;

  localparam int AXIS_BITS = 16;
  localparam int OUT_BITS  = 16;
  localparam int ITEMS_PER_PHASE = 122;
  localparam int RANDOM_PHASES   = 6;
  localparam int MAX_REPORTS     = 10;
  localparam logic [CFG_INDEX_BITS-1:0] SPARE_INDEX_LO = CFG_INDEX_BITS'(REG_RIGHT_MAX) + 1'b1;
  localparam logic [CFG_INDEX_BITS-1:0] SPARE_INDEX_HI = '1;

  typedef logic signed [AXIS_BITS-1:0] axis_t;
  typedef logic [OUT_BITS-1:0] level_t;

  typedef struct packed {
    level_t neutral;
    level_t rev_end;
    level_t fwd_end;
  } side_cal_t;

  typedef struct packed {
    level_t left_value;
    level_t right_value;
  } drive_pair_t;

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  level_t cfg_data;

  adm_axis_if  #(.AXIS_BITS(AXIS_BITS)) axis_ch ();
  adm_drive_if #(.OUT_BITS(OUT_BITS))   drive_ch ();

  arcade_drive_mixer_top #(
    .AXIS_BITS(AXIS_BITS),
    .OUT_BITS (OUT_BITS)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .in       (axis_ch),
    .out      (drive_ch),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  side_cal_t   left_cal;
  side_cal_t   right_cal;
  drive_pair_t expected_drive_q[$];
  int          mismatch_count;
  bit          no_gaps;

  always #2 clk = ~clk;

  function automatic bit gap_now();
    return !no_gaps && ($urandom_range(99) < 29);
  endfunction

  // Linear map from neutral toward the end picked by the drive sign, floored, then clamped.
  function automatic level_t scale_side(longint drive, side_cal_t cal);
    longint n, end_v, prod, res, lo, hi;
    n   = cal.neutral;
    res = n;
    if (drive != 0) begin
      end_v = (drive < 0) ? cal.rev_end : cal.fwd_end;
      prod  = (end_v - n) * ((drive < 0) ? -drive : drive);
      res   = n + (prod >>> (2 * AXIS_BITS - 1));
    end
    lo = (cal.rev_end < cal.fwd_end) ? cal.rev_end : cal.fwd_end;
    hi = (cal.rev_end < cal.fwd_end) ? cal.fwd_end : cal.rev_end;
    if (res > hi) res = hi;
    if (res < lo) res = lo;
    return level_t'(res);
  endfunction

  function automatic drive_pair_t mix_drive(axis_t x, axis_t y);
    longint full, lim, thr, str, a_thr, a_str, v, w, l, r;
    drive_pair_t pair;
    full  = longint'(1) << (AXIS_BITS - 1);
    lim   = longint'(1) << (2 * AXIS_BITS - 1);
    thr   = -longint'(x);
    str   = longint'(y);
    a_thr = (thr < 0) ? -thr : thr;
    a_str = (str < 0) ? -str : str;
    v = (full - a_str) * thr + thr * full;
    w = (full - a_thr) * str + str * full;
    l = v + w;
    r = v - w;
    if (l > lim)  l = lim;
    if (l < -lim) l = -lim;
    if (r > lim)  r = lim;
    if (r < -lim) r = -lim;
    pair.left_value  = scale_side(l, left_cal);
    pair.right_value = scale_side(r, right_cal);
    return pair;
  endfunction

  function automatic axis_t pick_axis();
    axis_t a;
    case ($urandom_range(9))
      0:       a = {1'b1, {(AXIS_BITS - 1){1'b0}}};
      1:       a = {1'b0, {(AXIS_BITS - 1){1'b1}}};
      2:       a = '0;
      3:       a = axis_t'($urandom_range(32)) - axis_t'(16);
      4:       a = axis_t'(32768 - $urandom_range(64));
      default: a = axis_t'($urandom);
    endcase
    return a;
  endfunction

  function automatic level_t pick_level();
    case ($urandom_range(5))
      0:       return '0;
      1:       return '1;
      default: return level_t'($urandom_range(65535));
    endcase
  endfunction

  // Half the time sort into rev_end <= neutral <= fwd_end, as a real servo range would be.
  function automatic side_cal_t pick_cal();
    level_t a, b, c, tmp;
    a = pick_level();
    b = pick_level();
    c = pick_level();
    if ($urandom_range(1)) begin
      if (a > b) begin tmp = a; a = b; b = tmp; end
      if (b > c) begin tmp = b; b = c; c = tmp; end
      if (a > b) begin tmp = a; a = b; b = tmp; end
      return '{neutral: b, rev_end: a, fwd_end: c};
    end
    return '{neutral: a, rev_end: b, fwd_end: c};
  endfunction

  // Call at a falling edge; returns at the falling edge after the item is taken.
  task automatic push_axis_pair(axis_t x, axis_t y);
    while (gap_now()) begin
      axis_ch.valid <= 1'b0;
      @(negedge clk);
    end
    axis_ch.valid  <= 1'b1;
    axis_ch.x_axis <= x;
    axis_ch.y_axis <= y;
    do @(posedge clk); while (!axis_ch.ready);
    expected_drive_q.insert(expected_drive_q.size(), mix_drive(x, y));
    @(negedge clk);
  endtask

  // Drop valid, wait for every pending drive pair, then let the pipeline drain.
  task automatic settle_idle();
    axis_ch.valid <= 1'b0;
    while (expected_drive_q.size() != 0) @(negedge clk);
    repeat (NUM_STAGES + 2) @(negedge clk);
  endtask

  task automatic write_cal_reg(logic [CFG_INDEX_BITS-1:0] idx, level_t val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_LEFT_NEUTRAL:  left_cal.neutral  = val;
      REG_LEFT_MIN:      left_cal.rev_end  = val;
      REG_LEFT_MAX:      left_cal.fwd_end  = val;
      REG_RIGHT_NEUTRAL: right_cal.neutral = val;
      REG_RIGHT_MIN:     right_cal.rev_end = val;
      REG_RIGHT_MAX:     right_cal.fwd_end = val;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic load_calibration(side_cal_t l, side_cal_t r);
    write_cal_reg(REG_LEFT_NEUTRAL, l.neutral);
    write_cal_reg(REG_LEFT_MIN, l.rev_end);
    write_cal_reg(REG_LEFT_MAX, l.fwd_end);
    write_cal_reg(REG_RIGHT_NEUTRAL, r.neutral);
    write_cal_reg(REG_RIGHT_MIN, r.rev_end);
    write_cal_reg(REG_RIGHT_MAX, r.fwd_end);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  // Full-scale axes, zero drive, and a one-step input on both axes, at reset calibration.
  task automatic run_axis_corners();
    axis_t neg_full, pos_full;
    neg_full = {1'b1, {(AXIS_BITS - 1){1'b0}}};
    pos_full = {1'b0, {(AXIS_BITS - 1){1'b1}}};
    push_axis_pair('0, '0);
    push_axis_pair(neg_full, '0);
    push_axis_pair(pos_full, '0);
    push_axis_pair('0, neg_full);
    push_axis_pair('0, pos_full);
    push_axis_pair(neg_full, neg_full);
    push_axis_pair(neg_full, pos_full);
    push_axis_pair(pos_full, neg_full);
    push_axis_pair(pos_full, pos_full);
    push_axis_pair(-axis_t'(1), axis_t'(1));
    settle_idle();
  endtask

  task automatic run_cal_probe();
    push_axis_pair({1'b1, {(AXIS_BITS - 1){1'b0}}}, '0);
    push_axis_pair({1'b0, {(AXIS_BITS - 1){1'b1}}}, {1'b1, {(AXIS_BITS - 1){1'b0}}});
    push_axis_pair('0, '0);
    settle_idle();
  endtask

  // Register extremes, min above max, neutral outside its range, writes to spare indexes.
  task automatic run_calibration_corners();
    load_calibration('{neutral: '0, rev_end: '0, fwd_end: '1},
                     '{neutral: '1, rev_end: '0, fwd_end: '1});
    run_cal_probe();
    load_calibration('{neutral: 1500, rev_end: 2000, fwd_end: 1000},
                     '{neutral: 30000, rev_end: '1, fwd_end: '0});
    run_cal_probe();
    load_calibration('{neutral: '1, rev_end: 100, fwd_end: 200},
                     '{neutral: '0, rev_end: 40000, fwd_end: 50000});
    // Spare indexes must leave every register alone.
    write_cal_reg(SPARE_INDEX_LO, 16'h1234);
    write_cal_reg(SPARE_INDEX_HI, '1);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
    run_cal_probe();
  endtask

  task automatic run_random_drive();
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      load_calibration(pick_cal(), pick_cal());
      // One phase runs with both sides streaming back to back.
      no_gaps = (phase == 2);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) push_axis_pair(pick_axis(), pick_axis());
      settle_idle();
      no_gaps = 1'b0;
    end
  endtask

  always @(negedge clk) drive_ch.ready <= !gap_now();

  always @(posedge clk) begin
    drive_pair_t want;
    if (!rst && drive_ch.valid && drive_ch.ready) begin
      if (expected_drive_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("%0t: unexpected drive pair left=%0d right=%0d", $time,
                   drive_ch.left_value, drive_ch.right_value);
      end else begin
        want = expected_drive_q.pop_front();
        if (drive_ch.left_value !== want.left_value ||
            drive_ch.right_value !== want.right_value) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("%0t: drive mismatch left exp=%0d got=%0d, right exp=%0d got=%0d",
                     $time, want.left_value, drive_ch.left_value,
                     want.right_value, drive_ch.right_value);
        end
      end
    end
  end

  initial begin
    clk            = 1'b0;
    rst            = 1'b1;
    cfg_wr_en      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    axis_ch.valid  = 1'b0;
    axis_ch.x_axis = '0;
    axis_ch.y_axis = '0;
    drive_ch.ready = 1'b0;
    no_gaps        = 1'b0;
    mismatch_count = 0;
    left_cal       = '{neutral: RST_NEUTRAL, rev_end: RST_MIN, fwd_end: RST_MAX};
    right_cal      = left_cal;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    run_axis_corners();
    run_calibration_corners();
    run_random_drive();

    repeat (NUM_STAGES + 4) @(negedge clk);
    if (mismatch_count == 0 && expected_drive_q.size() == 0) begin
      $display("** arcade_drive_mixer_top: PASSED **");
    end else begin
      $display("** arcade_drive_mixer_top: FAILED **");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("** arcade_drive_mixer_top: FAILED **");
    $finish;
  end

endmodule
